/* sv/prav_pkg.sv */
package prav_pkg;

    // store geometry; the store holds one entry per pixel, indexed modulo its depth
    localparam int PIXELS    = 4096;
    localparam int ADDR_W    = $clog2(PIXELS);
    localparam int IDX_W     = 12;
    localparam int SAMPLE_W  = 16;
    localparam int WIN_W     = 10;

    localparam logic [WIN_W-1:0] WINDOW_RESET = WIN_W'(10);

    // (n-1)*avg is an (WIN_W+1) x SAMPLE_W signed product, one more bit for the sample add
    localparam int PROD_W    = WIN_W + 1 + SAMPLE_W;
    localparam int ACC_W     = PROD_W + 1;

    // quotient magnitude never exceeds 2^(SAMPLE_W-1), so SAMPLE_W steps suffice
    localparam int DIV_STEPS = SAMPLE_W;
    localparam int STEP_W    = $clog2(DIV_STEPS);
    localparam int MAG_W     = SAMPLE_W + WIN_W;

    // commands from controller to datapath
    typedef struct packed {
        logic clr_write;
        logic load;
        logic mem_read;
        logic mul;
        logic acc;
        logic div_step;
        logic write_back;
        logic out_load;
    } prav_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic clr_last;
    } prav_status_t;

endpackage

/* sv/prav_ctrl.sv */
module prav_ctrl import prav_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_valid,
    output logic         s_ready,
    input  logic         m_ready,
    output logic         m_valid,
    input  prav_status_t status,
    output prav_cmd_t    cmd
);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_MUL,
        ST_ACC,
        ST_DIV,
        ST_WRITE,
        ST_OUT
    } state_t;

    state_t            state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              m_valid_reg, m_valid_next;
    logic              accept;
    logic              out_free;

    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign m_valid  = m_valid_reg;

    // command decode
    always_comb begin
        cmd            = '0;
        cmd.clr_write  = (state_reg == ST_CLEAR);
        cmd.load       = accept;
        cmd.mem_read   = (state_reg == ST_READ);
        cmd.mul        = (state_reg == ST_MUL);
        cmd.acc        = (state_reg == ST_ACC);
        cmd.div_step   = (state_reg == ST_DIV);
        cmd.write_back = (state_reg == ST_WRITE);
        cmd.out_load   = (state_reg == ST_OUT) && out_free;
    end

    // next state
    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                if (status.clr_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_READ;
                end
            end
            ST_READ:  state_next = ST_MUL;
            ST_MUL:   state_next = ST_ACC;
            ST_ACC: begin
                state_next = ST_DIV;
                step_next  = '0;
            end
            ST_DIV: begin
                step_next = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(DIV_STEPS - 1)) begin
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE: state_next = ST_OUT;
            ST_OUT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_CLEAR;
        endcase
    end

    // output valid: set on load, dropped when taken
    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    // state and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            step_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            step_reg    <= step_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

/* sv/prav_datapath.sv */
module prav_datapath import prav_pkg::*; (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  prav_cmd_t                  cmd,
    output prav_status_t               status,
    input  logic                       cfg_wr_en,
    input  logic [WIN_W-1:0]           cfg_wr_data,
    input  logic [IDX_W-1:0]           s_pixel_index,
    input  logic signed [SAMPLE_W-1:0] s_sample,
    input  logic                       s_frame_end,
    output logic [IDX_W-1:0]           m_pixel_out,
    output logic signed [SAMPLE_W-1:0] m_average,
    output logic                       m_last_of_frame
);

    // average store
    logic signed [SAMPLE_W-1:0] mem [PIXELS];

    logic [ADDR_W-1:0]          clr_addr_reg;
    logic [WIN_W-1:0]           window_reg;
    logic [WIN_W-1:0]           frame_cnt_reg;
    logic [IDX_W-1:0]           idx_reg;
    logic signed [SAMPLE_W-1:0] x_reg;
    logic                       fend_reg;
    logic [WIN_W-1:0]           n_reg;
    logic signed [SAMPLE_W-1:0] avg_reg;
    logic signed [PROD_W-1:0]   prod_reg;
    logic                       neg_reg;
    logic [WIN_W-1:0]           rem_reg;
    logic [SAMPLE_W-1:0]        quo_reg;
    logic [IDX_W-1:0]           out_idx_reg;
    logic signed [SAMPLE_W-1:0] out_avg_reg;
    logic                       out_last_reg;

    logic [WIN_W-1:0]           win_eff;
    logic [WIN_W-1:0]           n_next;
    logic [WIN_W-1:0]           n_minus_1;
    logic signed [ACC_W-1:0]    acc_sum;
    logic [ACC_W-1:0]           acc_abs;
    logic [WIN_W:0]             trial;
    logic                       trial_ge;
    logic signed [SAMPLE_W-1:0] result;
    logic [ADDR_W-1:0]          item_addr;

    assign status.clr_last = (clr_addr_reg == ADDR_W'(PIXELS - 1));

    // effective window and divisor n = min(frame count, window)
    assign win_eff   = (window_reg == '0) ? WIN_W'(1) : window_reg;
    assign n_next    = (frame_cnt_reg < win_eff) ? frame_cnt_reg : win_eff;
    assign n_minus_1 = n_reg - WIN_W'(1);
    assign item_addr = idx_reg[ADDR_W-1:0];

    // weighted sum and its magnitude
    assign acc_sum = ACC_W'(prod_reg) + ACC_W'(x_reg);
    assign acc_abs = acc_sum[ACC_W-1] ? ACC_W'(-acc_sum) : ACC_W'(acc_sum);

    // restoring divide step: one quotient bit per cycle
    assign trial    = {rem_reg, quo_reg[SAMPLE_W-1]};
    assign trial_ge = (trial >= {1'b0, n_reg});

    assign result = neg_reg ? SAMPLE_W'(-$signed(quo_reg)) : $signed(quo_reg);

    // control registers: clear address, window, frame count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_addr_reg  <= '0;
            window_reg    <= WINDOW_RESET;
            frame_cnt_reg <= WIN_W'(1);
        end else begin
            if (cmd.clr_write) begin
                clr_addr_reg <= clr_addr_reg + ADDR_W'(1);
            end
            if (cfg_wr_en) begin
                window_reg <= cfg_wr_data;
            end
            if (cmd.write_back && fend_reg && (frame_cnt_reg < win_eff)) begin
                frame_cnt_reg <= frame_cnt_reg + WIN_W'(1);
            end
        end
    end

    // store: clearing pass, read of the old average, write-back
    always_ff @(posedge aclk) begin
        if (cmd.clr_write) begin
            mem[clr_addr_reg] <= '0;
        end else if (cmd.write_back) begin
            mem[item_addr] <= result;
        end
        if (cmd.mem_read) begin
            avg_reg <= mem[item_addr];
        end
    end

    // request capture, multiply, accumulate, divide
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            idx_reg  <= s_pixel_index;
            x_reg    <= s_sample;
            fend_reg <= s_frame_end;
            n_reg    <= n_next;
        end
        if (cmd.mul) begin
            prod_reg <= $signed({1'b0, n_minus_1}) * avg_reg;
        end
        if (cmd.acc) begin
            neg_reg <= acc_sum[ACC_W-1];
            rem_reg <= acc_abs[MAG_W-1:SAMPLE_W];
            quo_reg <= acc_abs[SAMPLE_W-1:0];
        end else if (cmd.div_step) begin
            rem_reg <= trial_ge ? WIN_W'(trial - {1'b0, n_reg}) : trial[WIN_W-1:0];
            quo_reg <= {quo_reg[SAMPLE_W-2:0], trial_ge};
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_idx_reg  <= idx_reg;
            out_avg_reg  <= result;
            out_last_reg <= fend_reg;
        end
    end

    assign m_pixel_out     = out_idx_reg;
    assign m_average       = out_avg_reg;
    assign m_last_of_frame = out_last_reg;

endmodule

/* sv/pixel_running_average_unit.sv */
// Per-pixel running average over frames, signed Q8.8 samples.
// Input channel s_*: one pixel request per handshake (index, sample, end-of-frame
// mark). Result channel m_*: one result per request, echoing the index and mark
// with the updated average ((n-1)*avg + sample)/n, n = min(frame count, window).
// Configuration: cfg_wr_en/cfg_wr_data write the window in frames (0 acts as 1);
// write it only while no request is in flight.
// Sequence: after a request is accepted, the store read, multiply and accumulate
// steps run, then the divide runs one quotient bit per cycle, followed by write-back
// and output load. Requests are handled one at a time: a new request is accepted
// only after the previous one has been loaded into the output register.
// Reset (aresetn low, synchronous): window returns to 10, frame count to 1, and
// a clearing pass zeroes the 4096-entry average store one entry per cycle; s_ready
// stays low after reset is released until that pass has finished.
// Stall: a finished result waits in the output register while the next request is
// accepted and processed; that request holds at its end until m_ready frees the
// output register.
module pixel_running_average_unit import prav_pkg::*; (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_wr_en,
    input  logic [WIN_W-1:0]           cfg_wr_data,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [IDX_W-1:0]           s_pixel_index,
    input  logic signed [SAMPLE_W-1:0] s_sample,
    input  logic                       s_frame_end,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [IDX_W-1:0]           m_pixel_out,
    output logic signed [SAMPLE_W-1:0] m_average,
    output logic                       m_last_of_frame
);

    prav_cmd_t    cmd;
    prav_status_t status;

    // sequencer
    prav_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_ready (m_ready),
        .m_valid (m_valid),
        .status  (status),
        .cmd     (cmd)
    );

    // store, multiplier and divider
    prav_datapath u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .status          (status),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .s_pixel_index   (s_pixel_index),
        .s_sample        (s_sample),
        .s_frame_end     (s_frame_end),
        .m_pixel_out     (m_pixel_out),
        .m_average       (m_average),
        .m_last_of_frame (m_last_of_frame)
    );

endmodule
